// ===== design/cbe_pkg.sv =====
package cbe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_ITER_DEF = 32;
  localparam int LIMIT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL1_X     = 3'd0,
    CFG_CTRL1_Y     = 3'd1,
    CFG_CTRL2_X     = 3'd2,
    CFG_CTRL2_Y     = 3'd3,
    CFG_ITER_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_STEP,
    OP_DONE
  } op_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_THREE,
    SRC_T,
    SRC_X,
    SRC_K0,
    SRC_K1,
    SRC_K2,
    SRC_C1Y,
    SRC_C2Y,
    SRC_ACC,
    SRC_S0,
    SRC_S1,
    SRC_S2
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ACC,
    DST_S0,
    DST_S1,
    DST_S2
  } dst_t;

  typedef enum logic [1:0] {
    JC_NEVER,
    JC_CNT_ZERO,
    JC_CONTINUE
  } jc_t;

  typedef struct packed {
    op_t              op;
    src_t             a;
    src_t             b;
    dst_t             dst;
    jc_t              jc;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic go;
    logic bypass;
  } cbe_start_t;

  localparam logic [PC_W-1:0] UPC_ENTRY = 5'd0;
  localparam logic [PC_W-1:0] UPC_LOOP  = 5'd1;
  localparam logic [PC_W-1:0] UPC_CURVE = 5'd8;
  localparam logic [PC_W-1:0] UPC_DONE  = 5'd20;
  localparam logic [PC_W-1:0] NO_TARGET = 5'd0;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // skip the solve when no iterations are allowed
      5'd0:  w = '{OP_NOP,  SRC_ZERO, SRC_ZERO,  DST_NONE, JC_CNT_ZERO, UPC_CURVE};
      // horner evaluation of X(t) - x
      5'd1:  w = '{OP_MUL,  SRC_K0,   SRC_T,     DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd2:  w = '{OP_ADD,  SRC_ACC,  SRC_K1,    DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd3:  w = '{OP_MUL,  SRC_ACC,  SRC_T,     DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd4:  w = '{OP_ADD,  SRC_ACC,  SRC_K2,    DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd5:  w = '{OP_MUL,  SRC_ACC,  SRC_T,     DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd6:  w = '{OP_SUB,  SRC_ACC,  SRC_X,     DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd7:  w = '{OP_STEP, SRC_ZERO, SRC_ZERO,  DST_NONE, JC_CONTINUE, UPC_LOOP};
      // curve y at t
      5'd8:  w = '{OP_SUB,  SRC_ONE,  SRC_T,     DST_S0,   JC_NEVER,    NO_TARGET};
      5'd9:  w = '{OP_MUL,  SRC_T,    SRC_T,     DST_S1,   JC_NEVER,    NO_TARGET};
      5'd10: w = '{OP_MUL,  SRC_S1,   SRC_T,     DST_S2,   JC_NEVER,    NO_TARGET};
      5'd11: w = '{OP_MUL,  SRC_S1,   SRC_S0,    DST_S1,   JC_NEVER,    NO_TARGET};
      5'd12: w = '{OP_MUL,  SRC_S1,   SRC_C2Y,   DST_S1,   JC_NEVER,    NO_TARGET};
      5'd13: w = '{OP_MUL,  SRC_S1,   SRC_THREE, DST_S1,   JC_NEVER,    NO_TARGET};
      5'd14: w = '{OP_ADD,  SRC_S2,   SRC_S1,    DST_S2,   JC_NEVER,    NO_TARGET};
      5'd15: w = '{OP_MUL,  SRC_S0,   SRC_S0,    DST_S1,   JC_NEVER,    NO_TARGET};
      5'd16: w = '{OP_MUL,  SRC_T,    SRC_S1,    DST_S1,   JC_NEVER,    NO_TARGET};
      5'd17: w = '{OP_MUL,  SRC_S1,   SRC_C1Y,   DST_S1,   JC_NEVER,    NO_TARGET};
      5'd18: w = '{OP_MUL,  SRC_S1,   SRC_THREE, DST_S1,   JC_NEVER,    NO_TARGET};
      5'd19: w = '{OP_ADD,  SRC_S2,   SRC_S1,    DST_ACC,  JC_NEVER,    NO_TARGET};
      5'd20: w = '{OP_DONE, SRC_ZERO, SRC_ZERO,  DST_NONE, JC_NEVER,    NO_TARGET};
      default: w = '{OP_DONE, SRC_ZERO, SRC_ZERO, DST_NONE, JC_NEVER,   NO_TARGET};
    endcase
    return w;
  endfunction

endpackage

// ===== design/cubic_bezier_easing_unit.sv =====
// Cubic Bezier easing: for each progress beat x_position it solves X(t) = x
// by damped fixed-point steps starting at t = x, then returns Y(t) as a
// saturated signed Q2.FRAC_BITS value on eased_value. A single shared
// multiplier runs a short microprogram: a loop of error evaluations and
// damped steps, then the evaluation of Y(t). The loop runs at most
// iteration_limit times, clamped to MAX_ITER, and stops early when the error
// hits exactly zero. When both control points have x equal to y the solve
// is skipped and x_position itself becomes the result. One item is
// worked on at a time; a finished result waits in an output register while
// the next item is taken. Configuration writes (index 0..4: ctrl1_x, ctrl1_y,
// ctrl2_x, ctrl2_y, iteration_limit) are always accepted and must only be
// issued while the block is idle.
module cubic_bezier_easing_unit #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER = cbe_pkg::MAX_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [FRAC_BITS+2:0]            cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [FRAC_BITS:0]              x_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [FRAC_BITS+2:0]     eased_value
);
  import cbe_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam int KW = FRAC_BITS + 6;
  localparam int YW = FRAC_BITS + 3;
  localparam logic signed [KW-1:0] ONE_K = KW'(1) << FRAC_BITS;

  logic [FRAC_BITS:0]   ctrl1_x;
  logic signed [YW-1:0] ctrl1_y;
  logic [FRAC_BITS:0]   ctrl2_x;
  logic signed [YW-1:0] ctrl2_y;
  logic [LIMIT_W-1:0]   iteration_limit;

  logic signed [KW-1:0] c1x;
  logic signed [KW-1:0] c2x;
  logic signed [KW-1:0] c1x3;
  logic signed [KW-1:0] c2x3;
  logic signed [KW-1:0] k0;
  logic signed [KW-1:0] k1;
  logic signed [KW-1:0] k2;
  logic [CNT_W-1:0]     cnt_init;
  cbe_start_t           start;
  logic                 idle;
  logic                 res_valid;
  logic                 res_ready;
  logic signed [YW-1:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1_x <= '0;
      ctrl1_y <= '0;
      ctrl2_x <= (FRAC_BITS+1)'(1) << FRAC_BITS;
      ctrl2_y <= YW'(1) << FRAC_BITS;
      iteration_limit <= LIMIT_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CTRL1_X:    ctrl1_x <= cfg_data[FRAC_BITS:0];
        CFG_CTRL1_Y:    ctrl1_y <= $signed(cfg_data);
        CFG_CTRL2_X:    ctrl2_x <= cfg_data[FRAC_BITS:0];
        CFG_CTRL2_Y:    ctrl2_y <= $signed(cfg_data);
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // polynomial coefficients of X(t)
  always_comb begin
    c1x = $signed(KW'(ctrl1_x));
    c2x = $signed(KW'(ctrl2_x));
    c1x3 = (c1x <<< 1) + c1x;
    c2x3 = (c2x <<< 1) + c2x;
    k0 = ONE_K + c1x3 - c2x3;
    k1 = c2x3 - (c1x3 <<< 1);
    k2 = c1x3;
  end

  always_comb begin
    if (int'(iteration_limit) > MAX_ITER) begin
      cnt_init = CNT_W'(MAX_ITER);
    end else begin
      cnt_init = CNT_W'(iteration_limit);
    end
  end

  assign in_ready = idle;
  assign start.go = in_valid && in_ready;
  assign start.bypass = ($signed(YW'(ctrl1_x)) == ctrl1_y) &&
                        ($signed(YW'(ctrl2_x)) == ctrl2_y);

  cbe_engine #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .x         (x_position),
    .cnt_init  (cnt_init),
    .k0        (k0),
    .k1        (k1),
    .k2        (k2),
    .c1y       (ctrl1_y),
    .c2y       (ctrl2_y),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      eased_value <= res;
    end
  end

endmodule

// ===== design/cbe_engine.sv =====
module cbe_engine #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF,
  parameter int CNT_W = $clog2(cbe_pkg::MAX_ITER_DEF + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cbe_pkg::cbe_start_t         start,
  input  logic [FRAC_BITS:0]          x,
  input  logic [CNT_W-1:0]            cnt_init,
  input  logic signed [FRAC_BITS+5:0] k0,
  input  logic signed [FRAC_BITS+5:0] k1,
  input  logic signed [FRAC_BITS+5:0] k2,
  input  logic signed [FRAC_BITS+2:0] c1y,
  input  logic signed [FRAC_BITS+2:0] c2y,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [FRAC_BITS+2:0] res
);
  import cbe_pkg::*;

  localparam int AW = FRAC_BITS + 14;
  localparam int TW = FRAC_BITS + 3;
  localparam int MW = 2 * AW;

  localparam logic signed [AW-1:0] ONE_A   = AW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] THREE_A = AW'(3) << FRAC_BITS;
  localparam logic signed [MW-1:0] HALF_M  = MW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW:0]   LSB_H   = (AW+1)'(1);
  localparam logic signed [AW+1:0] T_MIN   = -((AW+2)'(4) << FRAC_BITS);
  localparam logic signed [AW+1:0] T_MAX   = ((AW+2)'(4) << FRAC_BITS) - (AW+2)'(1);
  localparam logic signed [AW-1:0] Y_MIN   = -(AW'(1) << FRAC_BITS);
  localparam logic signed [AW-1:0] Y_MAX   = AW'(2) << FRAC_BITS;

  logic                 busy;
  logic [PC_W-1:0]      pc;
  logic [CNT_W-1:0]     cnt;
  logic signed [TW-1:0] t;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] s0;
  logic signed [AW-1:0] s1;
  logic signed [AW-1:0] s2;
  logic [FRAC_BITS:0]   xr;

  ucode_t               uw;
  logic signed [AW-1:0] a_op;
  logic signed [AW-1:0] b_op;
  logic signed [MW-1:0] prod;
  logic signed [AW-1:0] alu;
  logic signed [AW:0]   half;
  logic signed [AW+1:0] t_diff;
  logic signed [TW-1:0] t_next;
  logic                 jump;
  logic [PC_W-1:0]      pc_next;

  assign uw = ucode(pc);

  function automatic logic signed [AW-1:0] pick(
    input src_t s, input logic signed [TW-1:0] tv, input logic [FRAC_BITS:0] xv,
    input logic signed [AW-1:0] accv, input logic signed [AW-1:0] s0v,
    input logic signed [AW-1:0] s1v, input logic signed [AW-1:0] s2v,
    input logic signed [FRAC_BITS+5:0] k0v, input logic signed [FRAC_BITS+5:0] k1v,
    input logic signed [FRAC_BITS+5:0] k2v, input logic signed [TW-1:0] c1v,
    input logic signed [TW-1:0] c2v);
    logic signed [AW-1:0] v;
    unique case (s)
      SRC_ZERO:  v = '0;
      SRC_ONE:   v = ONE_A;
      SRC_THREE: v = THREE_A;
      SRC_T:     v = AW'(tv);
      SRC_X:     v = $signed(AW'(xv));
      SRC_K0:    v = AW'(k0v);
      SRC_K1:    v = AW'(k1v);
      SRC_K2:    v = AW'(k2v);
      SRC_C1Y:   v = AW'(c1v);
      SRC_C2Y:   v = AW'(c2v);
      SRC_ACC:   v = accv;
      SRC_S0:    v = s0v;
      SRC_S1:    v = s1v;
      SRC_S2:    v = s2v;
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    a_op = pick(uw.a, t, xr, acc, s0, s1, s2, k0, k1, k2, c1y, c2y);
    b_op = pick(uw.b, t, xr, acc, s0, s1, s2, k0, k1, k2, c1y, c2y);
  end

  // rounded fixed-point product, half up
  assign prod = a_op * b_op;

  always_comb begin
    unique case (uw.op)
      OP_MUL:  alu = AW'((prod + HALF_M) >>> FRAC_BITS);
      OP_ADD:  alu = a_op + b_op;
      OP_SUB:  alu = a_op - b_op;
      default: alu = '0;
    endcase
  end

  // damped step: t - floor((err + 1) / 2), clamped
  always_comb begin
    half = ((AW+1)'(acc) + LSB_H) >>> 1;
    t_diff = (AW+2)'(t) - (AW+2)'(half);
    if (t_diff < T_MIN) begin
      t_next = TW'(T_MIN);
    end else if (t_diff > T_MAX) begin
      t_next = TW'(T_MAX);
    end else begin
      t_next = TW'(t_diff);
    end
  end

  always_comb begin
    unique case (uw.jc)
      JC_CNT_ZERO: jump = (cnt == '0);
      JC_CONTINUE: jump = (acc != '0) && (cnt != CNT_W'(1));
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  always_comb begin
    if (acc < Y_MIN) begin
      res = TW'(Y_MIN);
    end else if (acc > Y_MAX) begin
      res = TW'(Y_MAX);
    end else begin
      res = TW'(acc);
    end
  end

  assign idle = !busy;
  assign res_valid = busy && (uw.op == OP_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= UPC_ENTRY;
      cnt <= '0;
    end else if (start.go) begin
      busy <= 1'b1;
      pc <= start.bypass ? UPC_DONE : UPC_ENTRY;
      cnt <= cnt_init;
    end else if (busy) begin
      if (uw.op == OP_DONE) begin
        if (res_ready) begin
          busy <= 1'b0;
        end
      end else begin
        pc <= pc_next;
        if (uw.op == OP_STEP && acc != '0) begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      xr <= x;
      t <= TW'($signed({1'b0, x}));
      acc <= $signed(AW'(x));
    end else if (busy) begin
      if (uw.op == OP_STEP && acc != '0) begin
        t <= t_next;
      end
      if (uw.op == OP_MUL || uw.op == OP_ADD || uw.op == OP_SUB) begin
        unique case (uw.dst)
          DST_ACC: acc <= alu;
          DST_S0:  s0 <= alu;
          DST_S1:  s1 <= alu;
          DST_S2:  s2 <= alu;
          default: ;
        endcase
      end
    end
  end

endmodule
